/* rtl/alp_pkg.sv */
`default_nettype none

package alp_pkg;

  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned MODE_W    = 2;
  localparam int unsigned STAT_W    = 3;
  localparam int unsigned NUM_ALLOW = 7;
  localparam int unsigned CFG_DW    = 64;
  localparam int unsigned CFG_AW    = 6;
  localparam int unsigned REG_IDX_W = 3;

  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_SCAN  = 2'd0,
    MODE_DUMP  = 2'd1,
    MODE_CLEAR = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_NOT_MEMBER = 3'd0,
    ST_DUPLICATE  = 3'd1,
    ST_ADDED      = 3'd2,
    ST_FULL       = 3'd3,
    ST_LISTED     = 3'd4,
    ST_EMPTY      = 3'd5,
    ST_CLEARED    = 3'd6
  } status_e;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_ALLOW0  = 3'd0,
    REG_ALLOW1  = 3'd1,
    REG_ALLOW2  = 3'd2,
    REG_ALLOW3  = 3'd3,
    REG_ALLOW4  = 3'd4,
    REG_ALLOW5  = 3'd5,
    REG_ALLOW6  = 3'd6,
    REG_MAX_DEV = 3'd7
  } reg_idx_e;

  localparam addr_t ALLOW_RST [NUM_ALLOW] = '{
    48'h060001130039, 48'h060001130004, 48'h9a099d38e8dc,
    48'h0, 48'h0, 48'h0, 48'h0
  };
  localparam cnt_t MAX_DEV_RST = 3'd7;

  // control shared by every cell of the ring
  typedef struct packed {
    logic  shift;     // take neighbor's entry
    logic  load;      // write wdata into the cell at load_idx
    cnt_t  load_idx;
    addr_t wdata;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/alp_if.sv */
`default_nettype none

interface alp_req_if;
  logic                          valid;
  logic                          ready;
  logic [alp_pkg::MODE_W-1:0]    mode;
  logic [alp_pkg::ADDR_W-1:0]    address;

  modport source (output valid, output mode, output address, input ready);
  modport sink   (input valid, input mode, input address, output ready);
endinterface

interface alp_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [alp_pkg::STAT_W-1:0]    status;
  logic [alp_pkg::ADDR_W-1:0]    entry_address;
  logic [alp_pkg::CNT_W-1:0]     entry_count;
  logic                          last;

  modport source (output valid, output status, output entry_address,
                  output entry_count, output last, input ready);
  modport sink   (input valid, input status, input entry_address,
                  input entry_count, input last, output ready);
endinterface

`default_nettype wire

/* rtl/alp_cell.sv */
`default_nettype none

// One slot of the present ring: rotates toward the head or takes an append.
module alp_cell #(
  parameter int unsigned IDX = 0
) (
  input  wire logic                 clk_i,
  input  wire alp_pkg::cell_ctrl_t  ctrl_i,
  input  wire alp_pkg::addr_t       nb_i,
  output alp_pkg::addr_t            q_o
);

  alp_pkg::addr_t entry_q;
  alp_pkg::addr_t entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.shift) begin
      entry_d = nb_i;
    end else if (ctrl_i.load && (ctrl_i.load_idx == alp_pkg::CNT_W'(IDX))) begin
      entry_d = ctrl_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign q_o = entry_q;

endmodule

`default_nettype wire

/* rtl/allowlist_dedup_presence_table.sv */
`default_nettype none

// Channel   Dir  Fields                                         Transfer when
// req_i     in   mode, address                                  valid & ready
// rsp_o     out  status, entry_address, entry_count, last       valid & ready
// APB       in   psel/penable/pwrite/paddr/pwdata -> prdata     psel & penable
//
// Scan of an allowlisted address with room left: accept, one ring rotation
//   of ENTRIES steps, commit, result load.
// Scan that is full or not allowlisted, clear, empty dump: accept, result load.
// Dump: accept, then one ring rotation that lists each stored entry and
//   waits while the result register is stalled.
// Reset clears control state and the entry count; ring contents are
// don't-care until written. A stalled result holds in the output register.
module allowlist_dedup_presence_table #(
  parameter int unsigned ENTRIES = 7
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  alp_req_if.sink                           req_i,
  alp_rsp_if.source                         rsp_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [alp_pkg::CFG_AW-1:0]   paddr,
  input  wire logic [alp_pkg::CFG_DW-1:0]   pwdata,
  output logic      [alp_pkg::CFG_DW-1:0]   prdata,
  output logic                              pready
);

  localparam int unsigned STEP_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(ENTRIES - 1);
  localparam alp_pkg::cnt_t ENT_CNT = alp_pkg::CNT_W'(ENTRIES);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_WALK  = 5'b00010,   // rotate ring, look for duplicate
    S_FINAL = 5'b00100,   // ring home again: append or not
    S_DUMP  = 5'b01000,   // rotate ring, list entries
    S_EMIT  = 5'b10000    // load single result into output register
  } state_e;

  // ---------------- configuration registers ----------------
  alp_pkg::addr_t allow_q [alp_pkg::NUM_ALLOW];
  alp_pkg::cnt_t  max_dev_q;

  logic                            cfg_we;
  logic [alp_pkg::REG_IDX_W-1:0]   cfg_sel;

  assign pready  = 1'b1;
  assign cfg_we  = psel & penable & pwrite;
  assign cfg_sel = paddr[alp_pkg::CFG_AW-1:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_q   <= alp_pkg::ALLOW_RST;
      max_dev_q <= alp_pkg::MAX_DEV_RST;
    end else if (cfg_we) begin
      if (alp_pkg::reg_idx_e'(cfg_sel) == alp_pkg::REG_MAX_DEV) begin
        max_dev_q <= pwdata[alp_pkg::CNT_W-1:0];
      end else begin
        allow_q[cfg_sel] <= pwdata[alp_pkg::ADDR_W-1:0];
      end
    end
  end

  always_comb begin
    if (alp_pkg::reg_idx_e'(cfg_sel) == alp_pkg::REG_MAX_DEV) begin
      prdata = alp_pkg::CFG_DW'(max_dev_q);
    end else begin
      prdata = alp_pkg::CFG_DW'(allow_q[cfg_sel]);
    end
  end

  // ---------------- ring of cells ----------------
  alp_pkg::cell_ctrl_t ctrl;
  alp_pkg::addr_t      cell_q [ENTRIES];
  alp_pkg::addr_t      head;

  for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
    alp_cell #(.IDX(k)) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .nb_i   (cell_q[(k + 1) % ENTRIES]),
      .q_o    (cell_q[k])
    );
  end

  // entry j sits at the head on rotation step j
  assign head = cell_q[0];

  // ---------------- control ----------------
  state_e              state_q, state_d;
  alp_pkg::cnt_t       count_q, count_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                dup_q, dup_d;
  alp_pkg::addr_t      addr_q, addr_d;
  alp_pkg::status_e    pstat_q, pstat_d;
  alp_pkg::addr_t      pend_ea_q, pend_ea_d;

  logic                out_valid_q, out_valid_d;
  alp_pkg::status_e    out_status_q, out_status_d;
  alp_pkg::addr_t      out_addr_q, out_addr_d;
  alp_pkg::cnt_t       out_cnt_q, out_cnt_d;
  logic                out_last_q, out_last_d;

  logic                req_ready;
  logic                acc;
  logic                out_free;
  logic                member;
  logic                full;
  alp_pkg::cnt_t       limit;
  alp_pkg::cnt_t       step_c;
  logic                in_range;
  logic                advance;

  assign req_ready = (state_q == S_IDLE);
  assign acc       = req_i.valid & req_ready;
  assign out_free  = ~out_valid_q | rsp_o.ready;
  assign limit     = (max_dev_q < ENT_CNT) ? max_dev_q : ENT_CNT;
  assign full      = (count_q >= limit);
  assign step_c    = alp_pkg::CNT_W'(step_q);
  assign in_range  = (step_c < count_q);

  always_comb begin
    member = 1'b0;
    for (int k = 0; k < alp_pkg::NUM_ALLOW; k++) begin
      if (allow_q[k] == req_i.address) begin
        member = 1'b1;
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    step_d       = step_q;
    dup_d        = dup_q;
    addr_d       = addr_q;
    pstat_d      = pstat_q;
    pend_ea_d    = pend_ea_q;
    out_valid_d  = out_valid_q & ~rsp_o.ready;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    out_cnt_d    = out_cnt_q;
    out_last_d   = out_last_q;
    advance      = 1'b0;

    ctrl.shift    = 1'b0;
    ctrl.load     = 1'b0;
    ctrl.load_idx = count_q;
    ctrl.wdata    = addr_q;

    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          addr_d    = req_i.address;
          step_d    = '0;
          dup_d     = 1'b0;
          pend_ea_d = '0;
          unique case (alp_pkg::mode_e'(req_i.mode))
            alp_pkg::MODE_SCAN: begin
              if (full) begin
                pstat_d = alp_pkg::ST_FULL;
                state_d = S_EMIT;
              end else if (!member) begin
                pstat_d = alp_pkg::ST_NOT_MEMBER;
                state_d = S_EMIT;
              end else begin
                state_d = S_WALK;
              end
            end
            alp_pkg::MODE_DUMP: begin
              if (count_q == '0) begin
                pstat_d = alp_pkg::ST_EMPTY;
                state_d = S_EMIT;
              end else begin
                state_d = S_DUMP;
              end
            end
            alp_pkg::MODE_CLEAR: begin
              count_d = '0;
              pstat_d = alp_pkg::ST_CLEARED;
              state_d = S_EMIT;
            end
            alp_pkg::MODE_NONE: begin
              state_d = S_IDLE;   // ignored, no transfer out
            end
          endcase
        end
      end

      S_WALK: begin
        ctrl.shift = 1'b1;
        if (in_range && (head == addr_q)) begin
          dup_d = 1'b1;
        end
        step_d = step_q + 1'b1;
        if (step_q == LAST_STEP) begin
          step_d  = '0;
          state_d = S_FINAL;
        end
      end

      S_FINAL: begin
        if (dup_q) begin
          pstat_d = alp_pkg::ST_DUPLICATE;
        end else begin
          ctrl.load = 1'b1;
          count_d   = count_q + 1'b1;
          pstat_d   = alp_pkg::ST_ADDED;
          pend_ea_d = addr_q;
        end
        state_d = S_EMIT;
      end

      S_DUMP: begin
        if (in_range) begin
          if (out_free) begin
            advance      = 1'b1;
            out_valid_d  = 1'b1;
            out_status_d = alp_pkg::ST_LISTED;
            out_addr_d   = head;
            out_cnt_d    = count_q;
            out_last_d   = ((step_c + 1'b1) == count_q);
          end
        end else begin
          advance = 1'b1;     // finish the rotation so entries return home
        end
        if (advance) begin
          ctrl.shift = 1'b1;
          step_d     = step_q + 1'b1;
          if (step_q == LAST_STEP) begin
            step_d  = '0;
            state_d = S_IDLE;
          end
        end
      end

      S_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = pstat_q;
          out_addr_d   = pend_ea_q;
          out_cnt_d    = count_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      step_q      <= '0;
      dup_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      step_q      <= step_d;
      dup_q       <= dup_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q       <= addr_d;
    pstat_q      <= pstat_d;
    pend_ea_q    <= pend_ea_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
    out_cnt_q    <= out_cnt_d;
    out_last_q   <= out_last_d;
  end

  assign req_i.ready         = req_ready;
  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.status        = out_status_q;
  assign rsp_o.entry_address = out_addr_q;
  assign rsp_o.entry_count   = out_cnt_q;
  assign rsp_o.last          = out_last_q;

endmodule

`default_nettype wire

/* rtl/alp_checker.sv */
`default_nettype none

module alp_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          req_valid_i,
  input wire logic                          req_ready_i,
  input wire logic [alp_pkg::MODE_W-1:0]    req_mode_i,
  input wire logic                          rsp_valid_i,
  input wire logic                          rsp_ready_i,
  input wire logic [alp_pkg::STAT_W-1:0]    rsp_status_i,
  input wire logic [alp_pkg::ADDR_W-1:0]    rsp_addr_i,
  input wire logic [alp_pkg::CNT_W-1:0]     rsp_count_i,
  input wire logic                          rsp_last_i
);

  // any real command keeps the input closed for at least the next cycle
  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i && (req_mode_i != alp_pkg::MODE_NONE))
      |=> !req_ready_i)
    else $error("input ready right after a command transfer");

  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (rsp_status_i == alp_pkg::ST_CLEARED))
      |-> (rsp_count_i == '0) && (rsp_addr_i == '0) && rsp_last_i)
    else $error("clear result carries data");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && ((rsp_status_i == alp_pkg::ST_NOT_MEMBER) ||
                     (rsp_status_i == alp_pkg::ST_DUPLICATE) ||
                     (rsp_status_i == alp_pkg::ST_FULL) ||
                     (rsp_status_i == alp_pkg::ST_EMPTY)))
      |-> (rsp_addr_i == '0) && rsp_last_i)
    else $error("status without entry shows an address or is not last");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i)
      |=> rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_addr_i) &&
          $stable(rsp_count_i) && $stable(rsp_last_i))
    else $error("stalled result changed");

endmodule

bind allowlist_dedup_presence_table alp_checker u_alp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .req_mode_i   (req_i.mode),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_addr_i   (rsp_o.entry_address),
  .rsp_count_i  (rsp_o.entry_count),
  .rsp_last_i   (rsp_o.last)
);

`default_nettype wire
